[sv/lpft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared sizes and types for the LRU page-frame tracker.
// ----------------------------------------------------------------------------
package lpft_pkg;

    localparam int FRAMES    = 8;                      // built frame count
    localparam int PAGE_BITS = 16;                     // page bits compared and stored
    localparam int PAGE_W    = 16;                     // page port width
    localparam int RANK_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = 4;                      // occupancy / budget width
    localparam int CFG_W     = 4;
    localparam int TOTAL_W   = 32;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(8);

    typedef struct packed {
        logic              hit;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [CNT_W-1:0]  occupancy;
    } lookup_t;

endpackage

[sv/lru_page_frame_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_frame_tracker
// Fully associative LRU page-frame tracker with saturating hit/miss totals.
// ----------------------------------------------------------------------------
// One page reference is taken per clock unless a stalled consumer holds the
// result register. A reference sits in the input register, where it is
// compared against all frames at once, the frame ranks are updated and the
// result register is loaded; the result beat is valid once the reference has
// passed the input register and then the result register. The tag compare and
// rank update over the frame store are combinational.
// frames_in_use may be written only while the block is idle; 0 acts as 1 and
// values above the built frame count act as that count.
module lru_page_frame_tracker
    import lpft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frames_in_use_we,
    input  logic [CFG_W-1:0]    frames_in_use,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PAGE_W-1:0]   page_number,
    input  logic                final_reference,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic                evicted_valid,
    output logic [PAGE_W-1:0]   evicted_page,
    output logic [CNT_W-1:0]    occupancy,
    output logic [TOTAL_W-1:0]  hits_total,
    output logic [TOTAL_W-1:0]  misses_total,
    output logic                totals_final
);

    logic [CFG_W-1:0]     frames_in_use_reg;
    logic                 stage_valid_reg;
    logic [PAGE_BITS-1:0] stage_page_reg;
    logic                 stage_final_reg;
    logic                 fire;
    logic [CNT_W-1:0]     budget;
    lookup_t              lookup;

    logic [TOTAL_W-1:0]   hits_reg;
    logic [TOTAL_W-1:0]   hits_next;
    logic [TOTAL_W-1:0]   misses_reg;
    logic [TOTAL_W-1:0]   misses_next;
    logic                 out_valid_reg;
    lookup_t              out_lookup_reg;
    logic                 out_final_reg;

    assign fire     = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || fire;

    always_comb
    begin
        if (frames_in_use_reg == '0)
            budget = CNT_W'(1);
        else if (CNT_W'(frames_in_use_reg) > CNT_W'(FRAMES))
            budget = CNT_W'(FRAMES);
        else
            budget = CNT_W'(frames_in_use_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
        else if (frames_in_use_we)
            frames_in_use_reg <= frames_in_use;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_page_reg  <= page_number[PAGE_BITS-1:0];
            stage_final_reg <= final_reference;
        end
    end

    lpft_frames u_frames (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (fire),
        .page_key (stage_page_reg),
        .budget   (budget),
        .result   (lookup)
    );

    assign hits_next   = (lookup.hit && hits_reg != '1) ? hits_reg + TOTAL_W'(1) : hits_reg;
    assign misses_next = (!lookup.hit && misses_reg != '1) ?
                         misses_reg + TOTAL_W'(1) : misses_reg;

    // totals only move with a result beat, so they double as its fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_lookup_reg <= lookup;
            out_final_reg  <= stage_final_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_lookup_reg.hit;
    assign evicted_valid = out_lookup_reg.evicted_valid;
    assign evicted_page  = out_lookup_reg.evicted_page;
    assign occupancy     = out_lookup_reg.occupancy;
    assign hits_total    = hits_reg;
    assign misses_total  = misses_reg;
    assign totals_final  = out_final_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= CNT_W'(FRAMES) && occupancy != '0))
        else $error("occupancy out of range");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_valid |-> !hit)
        else $error("eviction reported on a hit");

    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page not zero");

    a_totals_move: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (hits_reg != $past(hits_reg) || misses_reg != $past(misses_reg)
                  || $past(hits_reg) == '1 || $past(misses_reg) == '1))
        else $error("totals did not advance");
`endif

endmodule

[sv/lpft_frames.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpft_frames
// Frame store with parallel tag compare, recency ranks and LRU victim pick.
// ----------------------------------------------------------------------------
module lpft_frames
    import lpft_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  logic [PAGE_BITS-1:0] page_key,
    input  logic [CNT_W-1:0]     budget,
    output lookup_t              result
);

    logic [PAGE_BITS-1:0] pages_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    valid_next;
    logic [RANK_W-1:0]    rank_reg  [FRAMES];
    logic [RANK_W-1:0]    rank_next [FRAMES];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic [FRAMES-1:0]    found;
    logic [FRAMES-1:0]    victim;
    logic [FRAMES-1:0]    free_sel;
    logic [FRAMES-1:0]    sel;
    logic                 hit;
    logic                 full;
    logic                 fill;
    logic [RANK_W-1:0]    lru_rank;
    logic [RANK_W-1:0]    found_rank;
    logic [CNT_W-1:0]     limit;
    logic [PAGE_BITS-1:0] victim_page;

    assign full     = (count_reg >= budget);
    // ranks of valid frames are 0..count-1, so the LRU frame holds count-1
    assign lru_rank = RANK_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        logic seen_hit;
        logic seen_free;
        seen_hit    = 1'b0;
        seen_free   = 1'b0;
        found       = '0;
        free_sel    = '0;
        victim      = '0;
        found_rank  = '0;
        victim_page = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (valid_reg[i] && pages_reg[i] == page_key && !seen_hit)
            begin
                found[i] = 1'b1;
                seen_hit = 1'b1;
            end
            if (!valid_reg[i] && !seen_free)
            begin
                free_sel[i] = 1'b1;
                seen_free   = 1'b1;
            end
            victim[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            if (found[i])
                found_rank = found_rank | rank_reg[i];
            if (victim[i])
                victim_page = victim_page | pages_reg[i];
        end
    end

    assign hit  = |found;
    assign fill = !hit && !full;

    always_comb
    begin
        if (hit)
        begin
            sel   = found;
            limit = CNT_W'(found_rank);
        end
        else if (full)
        begin
            sel   = victim;
            limit = CNT_W'(lru_rank);
        end
        else
        begin
            sel   = free_sel;
            limit = CNT_W'(FRAMES);   // every resident frame ages
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (sel[i])
            begin
                rank_next[i]  = '0;
                valid_next[i] = 1'b1;
            end
            else if (valid_reg[i] && CNT_W'(rank_reg[i]) < limit)
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
        count_next = fill ? count_reg + CNT_W'(1) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
                rank_reg[i] <= '0;
        end
        else if (update)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < FRAMES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && !hit)
        begin
            for (int i = 0; i < FRAMES; i++)
                if (sel[i])
                    pages_reg[i] <= page_key;
        end
    end

    always_comb
    begin
        result.hit           = hit;
        result.evicted_valid = !hit && full;
        result.evicted_page  = (!hit && full) ? PAGE_W'(victim_page) : '0;
        result.occupancy     = count_next;
    end

endmodule
